### design/lmcf_pkg.sv
package lmcf_pkg;

  localparam int MaxModules = 4;
  localparam int MaxVirtualModules = 16;
  localparam int NumRows = 8;
  localparam int FrameDepth = NumRows * MaxVirtualModules;
  localparam int ShadowDepth = NumRows * MaxModules;

  localparam logic [3:0] OP_SET_PIXEL = 4'd0;
  localparam logic [3:0] OP_CLR_PIXEL = 4'd1;
  localparam logic [3:0] OP_ROW_ON    = 4'd2;
  localparam logic [3:0] OP_ROW_OFF   = 4'd3;
  localparam logic [3:0] OP_ALL_ON    = 4'd4;
  localparam logic [3:0] OP_ALL_OFF   = 4'd5;
  localparam logic [3:0] OP_SCROLL    = 4'd6;
  localparam logic [3:0] OP_FLUSH     = 4'd7;
  localparam logic [3:0] OP_INTENSITY = 4'd8;
  localparam logic [3:0] OP_INIT      = 4'd9;
  localparam logic [3:0] OP_SHUTDOWN  = 4'd10;

  localparam logic [1:0] CFG_MODULE_COUNT    = 2'd0;
  localparam logic [1:0] CFG_VIRTUAL_MODULES = 2'd1;
  localparam logic [1:0] CFG_REVERSE_BITS    = 2'd2;

  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [3:0] REG_SCAN      = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
  localparam logic [3:0] REG_TEST      = 4'hF;
  localparam logic [3:0] INIT_LAST_STEP = 4'd13;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       frame_end;
  } word_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

  // power-up sequence: digit rows, decode, intensity, scan limit, run, test off
  function automatic logic [11:0] init_word(input logic [3:0] step);
    logic [11:0] w;
    case (step)
      4'd9:    w = {REG_DECODE, 8'h00};
      4'd10:   w = {REG_INTENSITY, 8'h01};
      4'd11:   w = {REG_SCAN, 8'h07};
      4'd12:   w = {REG_SHUTDOWN, 8'h01};
      4'd13:   w = {REG_TEST, 8'h00};
      default: w = {step, 8'h00};
    endcase
    return w;
  endfunction

endpackage

### design/lmcf_ram.sv
module lmcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### design/led_matrix_chain_framebuffer.sv
// Frame store and serial word source for a chain of 8x8 LED matrix modules.
// One command is taken at a time; in_stall stays high until its last word has
// left the holding stage; words wait in the output register while out_stall
// is high. The frame store has one read and one write port. A pixel edit
// reads its byte and writes it back, a fill writes virtual_modules bytes per
// row, a flush copies min(mc,vm) bytes per row and sends module_count words
// per dirty row, a scroll shifts each row by one pixel and sends module_count
// words per row; chain commands send module_count words (init: 14 per module).
// Writing virtual_modules clears the frame at once via per-byte valid bits.
module led_matrix_chain_framebuffer import lmcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_opcode,
  input  logic [2:0] in_row,
  input  logic [6:0] in_column,
  input  logic       in_wrap,
  input  logic       in_flush_after,
  input  logic [7:0] in_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_word_address,
  output logic [7:0] out_word_data,
  output logic       out_frame_end,
  output logic       out_last
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PIX_RD  = 4'd1;
  localparam logic [3:0] S_PIX_WR  = 4'd2;
  localparam logic [3:0] S_FILL    = 4'd3;
  localparam logic [3:0] S_FL_RD   = 4'd4;
  localparam logic [3:0] S_FL_WR   = 4'd5;
  localparam logic [3:0] S_FL_EMIT = 4'd6;
  localparam logic [3:0] S_SC_RD   = 4'd7;
  localparam logic [3:0] S_SC_WR   = 4'd8;
  localparam logic [3:0] S_SC_FIX  = 4'd9;
  localparam logic [3:0] S_SC_ERD  = 4'd10;
  localparam logic [3:0] S_SC_EMIT = 4'd11;
  localparam logic [3:0] S_CHAIN   = 4'd12;
  localparam logic [3:0] S_END     = 4'd13;

  logic [3:0] state_r;
  logic [3:0] op_r;
  logic [2:0] row_r;
  logic [6:0] col_r;
  logic       wrap_r;
  logic       fl_r;
  logic [7:0] level_r;
  logic [2:0] r_r;
  logic [3:0] k_r;
  logic [1:0] w_r;
  logic [3:0] step_r;
  logic       carry_r;
  logic [7:0] top_r;
  logic [7:0] dirty_r;
  logic [7:0] shadow_r [ShadowDepth];
  logic [FrameDepth-1:0] vld_r;
  logic       vld_q_r;
  logic [2:0] mc_cfg_r;
  logic [4:0] vm_cfg_r;
  logic       rb_r;
  logic       pend_v_r;
  word_t      pend_r;
  logic       out_v_r;
  word_t      out_r;
  logic       out_last_r;

  logic [2:0] mc_eff;
  logic [4:0] vm_eff;
  logic [1:0] mc_m1;
  logic [3:0] vm_m1;
  logic [1:0] tm_m1;
  logic [1:0] j_idx;
  logic       ram_we;
  logic [6:0] ram_waddr;
  logic [7:0] ram_wdata;
  logic [6:0] ram_raddr;
  logic [7:0] ram_rdata;
  logic [7:0] rd;
  logic [7:0] sc_byte;
  logic       emit_req;
  word_t      emit_w;
  logic [7:0] emit_raw;
  logic [11:0] iw;
  logic       can_push;
  logic       emit_ok;
  logic       emit_fire;
  logic       end_push;
  logic       fill_on;

  always_comb begin
    if (mc_cfg_r == 3'd0) begin
      mc_eff = 3'd1;
    end else if (mc_cfg_r > 3'(MaxModules)) begin
      mc_eff = 3'(MaxModules);
    end else begin
      mc_eff = mc_cfg_r;
    end
    if (vm_cfg_r == 5'd0) begin
      vm_eff = 5'd1;
    end else if (vm_cfg_r > 5'(MaxVirtualModules)) begin
      vm_eff = 5'(MaxVirtualModules);
    end else begin
      vm_eff = vm_cfg_r;
    end
  end

  assign mc_m1 = 2'(mc_eff - 3'd1);
  assign vm_m1 = 4'(vm_eff - 5'd1);
  assign tm_m1 = ({2'b00, mc_eff} < vm_eff) ? mc_m1 : vm_m1[1:0];
  assign j_idx = mc_m1 - w_r;
  assign rd = vld_q_r ? ram_rdata : 8'h00;
  assign sc_byte = {carry_r, rd[7:1]};
  assign fill_on = (op_r == OP_ROW_ON) || (op_r == OP_ALL_ON);
  assign iw = init_word(step_r);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = {r_r, k_r};
    ram_wdata = 8'h00;
    ram_raddr = {r_r, k_r};
    case (state_r)
      S_PIX_RD: begin
        ram_raddr = {row_r, col_r[6:3]};
      end
      S_PIX_WR: begin
        ram_we = 1'b1;
        ram_waddr = {row_r, col_r[6:3]};
        ram_wdata = (op_r == OP_SET_PIXEL) ? (rd | (8'h01 << col_r[2:0]))
                                           : (rd & ~(8'h01 << col_r[2:0]));
      end
      S_FILL: begin
        ram_we = 1'b1;
        ram_wdata = fill_on ? 8'hFF : 8'h00;
      end
      S_SC_WR: begin
        ram_we = 1'b1;
        ram_wdata = sc_byte;
      end
      S_SC_FIX: begin
        ram_we = wrap_r && carry_r;
        ram_waddr = {r_r, vm_m1};
        ram_wdata = top_r | 8'h80;
      end
      S_SC_ERD, S_SC_EMIT: begin
        ram_raddr = {r_r, 2'b00, j_idx};
      end
      default: begin
      end
    endcase
  end

  lmcf_ram #(.WIDTH(8), .DEPTH(FrameDepth)) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    emit_req = 1'b0;
    emit_raw = 8'h00;
    emit_w.addr = 4'({1'b0, r_r} + 4'd1);
    emit_w.frame_end = (w_r == mc_m1);
    case (state_r)
      S_FL_EMIT: begin
        emit_req = 1'b1;
        emit_raw = shadow_r[{r_r, j_idx}];
      end
      S_SC_EMIT: begin
        emit_req = 1'b1;
        emit_raw = ({3'b000, j_idx} < vm_eff) ? rd : 8'h00;
      end
      default: begin
      end
    endcase
    emit_w.data = rb_r ? rev8(emit_raw) : emit_raw;
    if (state_r == S_CHAIN) begin
      emit_req = 1'b1;
      case (op_r)
        OP_INTENSITY: begin
          emit_w.addr = REG_INTENSITY;
          emit_w.data = level_r;
        end
        OP_SHUTDOWN: begin
          emit_w.addr = REG_SHUTDOWN;
          emit_w.data = 8'h00;
        end
        default: begin
          emit_w.addr = iw[11:8];
          emit_w.data = iw[7:0];
        end
      endcase
    end
  end

  assign can_push = !out_v_r || !out_stall;
  assign emit_ok = !pend_v_r || can_push;
  assign emit_fire = emit_req && emit_ok;
  assign end_push = (state_r == S_END) && pend_v_r && can_push;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_word_address = out_r.addr;
  assign out_word_data = out_r.data;
  assign out_frame_end = out_r.frame_end;
  assign out_last = out_last_r;

  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[ram_raddr];
    if (in_valid && !in_stall) begin
      op_r <= in_opcode;
      row_r <= in_row;
      col_r <= in_column;
      wrap_r <= in_wrap;
      fl_r <= in_flush_after;
      level_r <= in_level;
    end
    if (emit_fire) begin
      pend_r <= emit_w;
    end
    if ((emit_fire && pend_v_r) || end_push) begin
      out_r <= pend_r;
      out_last_r <= end_push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      r_r <= 3'd0;
      k_r <= 4'd0;
      w_r <= 2'd0;
      step_r <= 4'd0;
      carry_r <= 1'b0;
      top_r <= 8'h00;
      dirty_r <= 8'h00;
      vld_r <= '0;
      mc_cfg_r <= 3'd4;
      vm_cfg_r <= 5'd4;
      rb_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < ShadowDepth; i++) begin
        shadow_r[i] <= 8'h00;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODULE_COUNT: mc_cfg_r <= cfg_data[2:0];
          CFG_VIRTUAL_MODULES: begin
            vm_cfg_r <= cfg_data;
            vld_r <= '0;
          end
          CFG_REVERSE_BITS: rb_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end

      if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
      if ((emit_fire && pend_v_r) || end_push) begin
        out_v_r <= 1'b1;
      end
      if (emit_fire) begin
        pend_v_r <= 1'b1;
      end else if (end_push) begin
        pend_v_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            r_r <= 3'd0;
            k_r <= 4'd0;
            w_r <= 2'd0;
            step_r <= 4'd0;
            carry_r <= 1'b0;
            case (in_opcode)
              OP_SET_PIXEL, OP_CLR_PIXEL: begin
                if ({1'b0, in_column[6:3]} < vm_eff) begin
                  state_r <= S_PIX_RD;
                end
              end
              OP_ROW_ON, OP_ROW_OFF: begin
                r_r <= in_row;
                state_r <= S_FILL;
              end
              OP_ALL_ON, OP_ALL_OFF: state_r <= S_FILL;
              OP_SCROLL: begin
                k_r <= vm_m1;
                state_r <= S_SC_RD;
              end
              OP_FLUSH: state_r <= S_FL_RD;
              OP_INTENSITY, OP_INIT, OP_SHUTDOWN: state_r <= S_CHAIN;
              default: begin
              end
            endcase
          end
        end
        S_PIX_RD: state_r <= S_PIX_WR;
        S_PIX_WR: begin
          dirty_r[row_r] <= 1'b1;
          r_r <= 3'd0;
          k_r <= 4'd0;
          state_r <= fl_r ? S_FL_RD : S_END;
        end
        S_FILL: begin
          dirty_r[r_r] <= 1'b1;
          if (k_r == vm_m1) begin
            k_r <= 4'd0;
            if ((op_r == OP_ALL_ON || op_r == OP_ALL_OFF) && r_r != 3'd7) begin
              r_r <= r_r + 3'd1;
            end else begin
              r_r <= 3'd0;
              state_r <= fl_r ? S_FL_RD : S_END;
            end
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_FL_RD: state_r <= S_FL_WR;
        S_FL_WR: begin
          shadow_r[{r_r, k_r[1:0]}] <= rd;
          w_r <= 2'd0;
          if (k_r[1:0] == tm_m1) begin
            k_r <= 4'd0;
            if (dirty_r[r_r]) begin
              state_r <= S_FL_EMIT;
            end else if (r_r == 3'd7) begin
              dirty_r <= 8'h00;
              state_r <= S_END;
            end else begin
              r_r <= r_r + 3'd1;
              state_r <= S_FL_RD;
            end
          end else begin
            k_r <= k_r + 4'd1;
            state_r <= S_FL_RD;
          end
        end
        S_FL_EMIT: begin
          if (emit_ok) begin
            if (w_r == mc_m1) begin
              if (r_r == 3'd7) begin
                dirty_r <= 8'h00;
                state_r <= S_END;
              end else begin
                r_r <= r_r + 3'd1;
                state_r <= S_FL_RD;
              end
            end else begin
              w_r <= w_r + 2'd1;
            end
          end
        end
        S_SC_RD: state_r <= S_SC_WR;
        S_SC_WR: begin
          carry_r <= rd[0];
          if (k_r == vm_m1) begin
            top_r <= sc_byte;
          end
          if (k_r == 4'd0) begin
            state_r <= S_SC_FIX;
          end else begin
            k_r <= k_r - 4'd1;
            state_r <= S_SC_RD;
          end
        end
        S_SC_FIX: begin
          w_r <= 2'd0;
          state_r <= S_SC_ERD;
        end
        S_SC_ERD: state_r <= S_SC_EMIT;
        S_SC_EMIT: begin
          if (emit_ok) begin
            if (w_r == mc_m1) begin
              if (r_r == 3'd7) begin
                state_r <= S_END;
              end else begin
                r_r <= r_r + 3'd1;
                k_r <= vm_m1;
                carry_r <= 1'b0;
                state_r <= S_SC_RD;
              end
            end else begin
              w_r <= w_r + 2'd1;
              state_r <= S_SC_ERD;
            end
          end
        end
        S_CHAIN: begin
          if (emit_ok) begin
            if (w_r == mc_m1) begin
              w_r <= 2'd0;
              if (op_r == OP_INIT && step_r != INIT_LAST_STEP) begin
                step_r <= step_r + 4'd1;
              end else begin
                state_r <= S_END;
              end
            end else begin
              w_r <= w_r + 2'd1;
            end
          end
        end
        S_END: begin
          if (!pend_v_r || can_push) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("word left pending while idle");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_last_r) |-> out_r.frame_end)
    else $error("last word without chip select release");

  a_flush_row_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FL_EMIT) |-> dirty_r[r_r])
    else $error("flush sending a clean row");
`endif

endmodule
